// ===== design/rms_pkg.sv =====
// Shared types and constants of the running median sampler.
// Used by the interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package rms_pkg;

    localparam int HEIGHT_W   = 16;
    localparam int CMD_W      = 2;
    localparam int OUT_CNT_W  = 7;
    localparam int INTER_W    = 7;
    localparam int LIMIT_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    typedef logic signed [HEIGHT_W-1:0] t_height;

    // input commands
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LIMIT = 2'd1;

    // reset values of the configuration registers
    localparam logic [INTER_W-1:0] INTER_COUNT_RST = 7'd8;
    localparam logic [LIMIT_W-1:0] SAMPLE_LIMIT_RST = 6'd63;

    // controller to datapath commands
    typedef struct packed {
        logic clear;   // session begin: empty store, enable
        logic stop;    // session end: disable
        logic load;    // take a sample, start insertion and remainder
        logic shift;   // move the fetched entry up one slot
        logic place;   // write the sample at the current slot
        logic rd_med;  // fetch the median entry
        logic emit;    // load the output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic active;
        logic full;
        logic count_zero;
        logic greater;
        logic pos_one;
        logic rem_done;
        logic report;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== design/rms_if.sv =====
// Handshake channel interfaces of the running median sampler.
// Depends on rms_pkg for field widths.
`timescale 1ns / 1ps

interface rms_in_if;
    logic                            valid;
    logic                            ready;
    logic [rms_pkg::CMD_W-1:0]       command;
    rms_pkg::t_height                height;
    modport source(output valid, command, height, input ready);
    modport sink(input valid, command, height, output ready);
endinterface

interface rms_out_if;
    logic                            valid;
    logic                            ready;
    rms_pkg::t_height                median_height;
    logic                            is_final;
    logic [rms_pkg::OUT_CNT_W-1:0]   sample_count;
    modport source(output valid, median_height, is_final, sample_count, input ready);
    modport sink(input valid, median_height, is_final, sample_count, output ready);
endinterface

interface rms_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rms_pkg::CFG_IDX_W-1:0]   index;
    logic [rms_pkg::CFG_DATA_W-1:0]  data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== design/rms_ctrl.sv =====
// Sequencer of the running median sampler: decodes commands and steps
// the sorted insertion, remainder wait and median readout. Uses rms_pkg.
`timescale 1ns / 1ps

module rms_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [rms_pkg::CMD_W-1:0] i_command,
    output logic                      o_in_ready,
    output rms_pkg::t_dp_cmd          o_cmd,
    input  rms_pkg::t_dp_sts          i_sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_PUT,
        ST_WAIT,
        ST_MED
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_command)
                        rms_pkg::CMD_BEGIN: o_cmd.clear = 1'b1;
                        rms_pkg::CMD_END:   o_cmd.stop  = 1'b1;
                        rms_pkg::CMD_SAMPLE: begin
                            if (i_sts.active && !i_sts.full) begin
                                o_cmd.load = 1'b1;
                                n_state    = i_sts.count_zero ? ST_PUT : ST_CMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CMP: begin
                // fetched entry larger than the sample moves up
                if (i_sts.greater) begin
                    o_cmd.shift = 1'b1;
                    n_state     = i_sts.pos_one ? ST_PUT : ST_CMP;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = ST_WAIT;
                end
            end
            ST_PUT: begin
                o_cmd.place = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_sts.rem_done) begin
                    if (i_sts.report) begin
                        o_cmd.rd_med = 1'b1;
                        n_state      = ST_MED;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_MED: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/rms_datapath.sv =====
// Datapath of the running median sampler: sorted sample store, count,
// serial remainder unit and output register. Uses rms_pkg.
`timescale 1ns / 1ps

module rms_datapath #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rms_pkg::t_dp_cmd              i_cmd,
    output rms_pkg::t_dp_sts              o_sts,
    input  rms_pkg::t_height              i_height,
    input  logic [rms_pkg::INTER_W-1:0]   i_inter_count,
    input  logic [rms_pkg::LIMIT_W-1:0]   i_sample_limit,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output rms_pkg::t_height              o_median,
    output logic                          o_final,
    output logic [rms_pkg::OUT_CNT_W-1:0] o_count
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int BW = $clog2(CW + 1);
    localparam int IW = rms_pkg::INTER_W;

    rms_pkg::t_height r_mem [BUFFER_DEPTH];
    rms_pkg::t_height r_rd_data;
    rms_pkg::t_height r_value;
    logic [AW-1:0]    r_pos;
    logic [CW-1:0]    r_count;
    logic             r_active;
    logic [CW-1:0]    r_div;
    logic [IW-1:0]    r_rem;
    logic [BW-1:0]    r_bits;

    logic                          r_out_valid;
    rms_pkg::t_height              r_median;
    logic                          r_final;
    logic [rms_pkg::OUT_CNT_W-1:0] r_out_count;

    logic             w_rd_en;
    logic [AW-1:0]    w_rd_addr;
    logic             w_we;
    rms_pkg::t_height w_wr_data;
    logic [IW:0]      w_rem_sh;
    logic [IW:0]      w_rem_sub;
    logic [IW-1:0]    w_rem_next;
    logic             w_full;
    logic             w_fin;
    logic             w_inter;

    // store read address: slot below the insertion point, or the median
    always_comb begin
        w_rd_en   = i_cmd.load | i_cmd.shift | i_cmd.rd_med;
        w_rd_addr = '0;
        if (i_cmd.load) begin
            w_rd_addr = AW'(r_count - CW'(1));
        end else if (i_cmd.shift) begin
            w_rd_addr = r_pos - AW'(2);
        end else if (i_cmd.rd_med) begin
            w_rd_addr = AW'(r_count >> 1);
        end
    end

    assign w_we      = i_cmd.shift | i_cmd.place;
    assign w_wr_data = i_cmd.shift ? r_rd_data : r_value;

    // sample store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_pos] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // restoring remainder step: count mod intermediate_count, MSB first
    assign w_rem_sh   = {r_rem, r_div[CW-1]};
    assign w_rem_sub  = w_rem_sh - {1'b0, i_inter_count};
    assign w_rem_next = (w_rem_sh >= {1'b0, i_inter_count}) ? w_rem_sub[IW-1:0]
                                                              : w_rem_sh[IW-1:0];

    // report conditions on the updated count
    assign w_full  = (32'(r_count) >= BUFFER_DEPTH);
    assign w_fin   = (32'(r_count) > 32'(i_sample_limit)) || w_full;
    assign w_inter = (i_inter_count != '0) && (r_rem == '0);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_active    <= 1'b0;
            r_bits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.load) begin
                r_count <= r_count + CW'(1);
            end

            if (i_cmd.clear) begin
                r_active <= 1'b1;
            end else if (i_cmd.stop || (i_cmd.emit && w_fin)) begin
                r_active <= 1'b0;
            end

            if (i_cmd.load) begin
                r_bits <= BW'(CW);
            end else if (r_bits != '0) begin
                r_bits <= r_bits - BW'(1);
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_height;
            r_pos   <= AW'(r_count);
            r_div   <= r_count + CW'(1);
            r_rem   <= '0;
        end else begin
            if (i_cmd.shift) begin
                r_pos <= r_pos - AW'(1);
            end
            if (r_bits != '0) begin
                r_rem <= w_rem_next;
                r_div <= r_div << 1;
            end
        end

        if (i_cmd.emit) begin
            r_median    <= r_rd_data;
            r_final     <= w_fin;
            r_out_count <= rms_pkg::OUT_CNT_W'(r_count);
        end
    end

    // status to the controller
    always_comb begin
        o_sts.active     = r_active;
        o_sts.full       = w_full;
        o_sts.count_zero = (r_count == '0);
        o_sts.greater    = (r_rd_data > r_value);
        o_sts.pos_one    = (r_pos == AW'(1));
        o_sts.rem_done   = (r_bits == '0);
        o_sts.report     = w_inter | w_fin;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_median    = r_median;
    assign o_final     = r_final;
    assign o_count     = r_out_count;

endmodule

// ===== design/running_median_sampler_core.sv =====
// Running median sampler. A sample is inserted into the sorted store by moving the k stored
// entries larger than it up (one store slot moved per cycle), while a serial remainder unit runs
// W = clog2(BUFFER_DEPTH+1) steps. A report is read from the store once both are done, and it
// is loaded into the output register once the previous result has been taken. One item at a
// time, and the output register lets the next item in. Reset (synchronous,
// active low) empties the count, idles sampling, sets the registers to 8 and 63; no store clear.
`timescale 1ns / 1ps

module running_median_sampler_core #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rms_in_if.sink   i_in,
    rms_out_if.source o_out,
    rms_cfg_if.sink  i_cfg
);

    logic [rms_pkg::INTER_W-1:0] r_inter_count;
    logic [rms_pkg::LIMIT_W-1:0] r_sample_limit;

    rms_pkg::t_dp_cmd w_cmd;
    rms_pkg::t_dp_sts w_sts;
    logic             w_in_ready;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inter_count  <= rms_pkg::INTER_COUNT_RST;
            r_sample_limit <= rms_pkg::SAMPLE_LIMIT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rms_pkg::CFG_INTER_COUNT:  r_inter_count  <= i_cfg.data;
                rms_pkg::CFG_SAMPLE_LIMIT: r_sample_limit <= i_cfg.data[rms_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = w_in_ready;

    rms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_command  (i_in.command),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    rms_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_height       (i_in.height),
        .i_inter_count  (r_inter_count),
        .i_sample_limit (r_sample_limit),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_median       (o_out.median_height),
        .o_final        (o_out.is_final),
        .o_count        (o_out.sample_count)
    );

endmodule

// ===== design/rms_checker.sv =====
// Port-level checks of the running median sampler and their bind to the top level.
// Depends on running_median_sampler_core and rms_pkg.
`timescale 1ns / 1ps

module rms_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input rms_pkg::t_height              i_out_median,
    input logic                          i_out_final,
    input logic [rms_pkg::OUT_CNT_W-1:0] i_out_count
);

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result pending after reset");

    // a result is only produced from finished work, never on the edge after an intake
    a_no_result_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result appeared right after an item was taken");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_median)
            && $stable(i_out_final) && $stable(i_out_count)))
        else $error("stalled result changed");

endmodule

bind running_median_sampler_core rms_checker u_rms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_median (o_out.median_height),
    .i_out_final  (o_out.is_final),
    .i_out_count  (o_out.sample_count)
);

// ===== dv/running_median_sampler_core_tb.sv =====
// Self-checking testbench of running_median_sampler_core: handshake drivers, a median
// predictor with its own sorted store, and a scoreboard of pending reports.
// Depends on rms_pkg, the channel interfaces in rms_if.sv and the core itself.
`timescale 1ns / 1ps

module running_median_sampler_core_tb;

    localparam int DEPTH         = 64;
    localparam int TARGET_ITEMS  = 1200;
    localparam int PHASE_ITEMS   = 130;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    // codes the package leaves unnamed
    localparam logic [rms_pkg::CMD_W-1:0]     CMD_UNUSED  = 2'd3;
    localparam logic [rms_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [rms_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum {PAT_RANDOM, PAT_ASCEND, PAT_DESCEND, PAT_SAME, PAT_EXTREME, PAT_NARROW}
        t_pattern;

    // median predictor and queue of pending reports
    class median_scoreboard;
        typedef struct {
            rms_pkg::t_height                median;
            logic                            is_last;
            logic [rms_pkg::OUT_CNT_W-1:0]   held;
        } t_report;

        rms_pkg::t_height store [DEPTH];
        int      fill;
        int      period;
        int      limit;
        bit      enabled;
        t_report reports [$];
        int      errors;
        int      checked;

        function new();
            fill    = 0;
            enabled = 0;
            period  = rms_pkg::INTER_COUNT_RST;
            limit   = rms_pkg::SAMPLE_LIMIT_RST;
            errors  = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [rms_pkg::CFG_IDX_W-1:0] idx,
                              logic [rms_pkg::CFG_DATA_W-1:0] data);
            if (idx == rms_pkg::CFG_INTER_COUNT)
                period = data & 7'h7F;
            else if (idx == rms_pkg::CFG_SAMPLE_LIMIT)
                limit = data & 7'h3F;
        endfunction

        // returns 1 when the item changed state or produced a report
        function bit note_input(logic [rms_pkg::CMD_W-1:0] cmd, rms_pkg::t_height h);
            int      pos;
            int      mid;
            bit      inter_hit;
            bit      final_hit;
            t_report rep;
            if (cmd == rms_pkg::CMD_BEGIN) begin
                fill    = 0;
                enabled = 1;
                return 1;
            end
            if (cmd == rms_pkg::CMD_END) begin
                enabled = 0;
                return 1;
            end
            if (cmd != rms_pkg::CMD_SAMPLE || !enabled || fill >= DEPTH)
                return 0;
            // sorted insertion, ties keep arrival order
            pos = fill;
            while (pos > 0 && store[pos-1] > h) begin
                store[pos] = store[pos-1];
                pos--;
            end
            store[pos] = h;
            fill++;
            inter_hit = (period != 0) && (fill % period == 0);
            final_hit = (fill > limit) || (fill >= DEPTH);
            if (!inter_hit && !final_hit)
                return 1;
            mid = fill / 2;
            if (mid >= DEPTH)
                mid = DEPTH - 1;
            rep.median  = store[mid];
            rep.is_last = final_hit;
            rep.held    = fill[rms_pkg::OUT_CNT_W-1:0];
            reports.push_back(rep);
            if (final_hit)
                enabled = 0;
            return 1;
        endfunction

        function void check_result(rms_pkg::t_height med, logic last,
                                   logic [rms_pkg::OUT_CNT_W-1:0] held);
            t_report want;
            checked++;
            if (reports.size() == 0) begin
                $error("result with no report pending: median_height %0d", med);
                errors++;
                return;
            end
            want = reports.pop_front();
            if (med !== want.median) begin
                $error("median_height: expected %0d, actual %0d", want.median, med);
                errors++;
            end
            if (last !== want.is_last) begin
                $error("is_final: expected %0d, actual %0d", want.is_last, last);
                errors++;
            end
            if (held !== want.held) begin
                $error("sample_count: expected %0d, actual %0d", want.held, held);
                errors++;
            end
        endfunction

        function int pending();
            return reports.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rms_in_if  in_ch ();
    rms_out_if out_ch ();
    rms_cfg_if cfg_ch ();

    running_median_sampler_core #(
        .BUFFER_DEPTH(DEPTH)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    median_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;
    int n_items;
    int n_counted;
    int n_results;
    int n_settings;
    bit drained_once;

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // result sink: random back-pressure, plus one long hold-off
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result(out_ch.median_height, out_ch.is_final, out_ch.sample_count);
            n_results++;
            if (n_results == 25)
                hold_left = HOLD_CYCLES;
        end
    end

    // offer one item, wait for acceptance; ends at the accepting rising edge
    task automatic send_item(logic [rms_pkg::CMD_W-1:0] cmd, rms_pkg::t_height h);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.height  <= h;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_items++;
        if (sb.note_input(cmd, h))
            n_counted++;
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // block idle: no report pending and any silent sample finished
    task automatic settle();
        drop_valid();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [rms_pkg::CFG_IDX_W-1:0] idx,
                             logic [rms_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_setting(logic [rms_pkg::CFG_DATA_W-1:0] period,
                                 logic [rms_pkg::CFG_DATA_W-1:0] lim);
        settle();
        write_reg(rms_pkg::CFG_INTER_COUNT, period);
        write_reg(rms_pkg::CFG_SAMPLE_LIMIT, lim);
        n_settings++;
    endtask

    function automatic rms_pkg::t_height pick_height(t_pattern pat, int idx, int base,
                                                     int step);
        int v;
        case (pat)
            PAT_ASCEND:  v = base + idx * step;
            PAT_DESCEND: v = base - idx * step;
            PAT_SAME:    v = base;
            PAT_EXTREME: begin
                case ($urandom_range(3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            PAT_NARROW:  v = base + $urandom_range(6) - 3;
            default:     v = $urandom_range(65535);
        endcase
        return rms_pkg::t_height'(v[rms_pkg::HEIGHT_W-1:0]);
    endfunction

    function automatic rms_pkg::t_height any_height();
        return rms_pkg::t_height'($urandom_range(65535));
    endfunction

    // one session: mostly begin, samples, end; some noise and broken sequences
    task automatic run_session();
        int       roll;
        int       n;
        int       base;
        int       step;
        t_pattern pat;
        roll = $urandom_range(99);
        if (roll < 8)
            send_item(rms_pkg::CMD_SAMPLE, any_height());
        else if (roll < 12)
            send_item(CMD_UNUSED, any_height());
        send_item(rms_pkg::CMD_BEGIN, any_height());
        roll = $urandom_range(99);
        if (roll < 60)
            n = $urandom_range(sb.limit + 1, 1);
        else if (roll < 88)
            n = sb.limit + 1 + $urandom_range(3);
        else
            n = $urandom_range(68, 60);
        pat  = t_pattern'($urandom_range(5));
        base = $urandom_range(65535) - 32768;
        step = $urandom_range(500, 1);
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (roll < 3)
                send_item(CMD_UNUSED, any_height());
            else if (roll < 5)
                send_item(rms_pkg::CMD_END, any_height());
            else if (roll < 6)
                send_item(rms_pkg::CMD_BEGIN, any_height());
            send_item(rms_pkg::CMD_SAMPLE, pick_height(pat, i, base, step));
            // one pause of the sender until every report is back
            if (!drained_once && n_counted >= 600) begin
                drop_valid();
                wait_drained();
                drained_once = 1;
            end
        end
        if ($urandom_range(99) < 70)
            send_item(rms_pkg::CMD_END, any_height());
    endtask

    // settings of the random part: (period, limit write data)
    logic [rms_pkg::CFG_DATA_W-1:0] set_period [9] = '{7'd8, 7'd1, 7'd0, 7'd64, 7'd127,
                                                       7'd3, 7'd5, 7'd16, 7'd2};
    logic [rms_pkg::CFG_DATA_W-1:0] set_limit  [9] = '{7'd63, 7'd1, 7'd63, 7'd63, 7'd10,
                                                       7'h45, 7'd0, 7'd40, 7'd63};

    initial begin
        int phase;
        sb            = new();
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.command = rms_pkg::CMD_SAMPLE;
        in_ch.height  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = rms_pkg::CFG_INTER_COUNT;
        cfg_ch.data   = '0;
        tx_idle_pct   = 22;
        rx_idle_pct   = 65;
        hold_left     = 0;
        n_items       = 0;
        n_counted     = 0;
        n_results     = 0;
        n_settings    = 1;
        drained_once  = 0;
        phase         = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings: idle noise, extremes, intermediate report at 8
        send_item(rms_pkg::CMD_SAMPLE, 16'sd100);
        send_item(CMD_UNUSED, 16'sh7FFF);
        send_item(rms_pkg::CMD_BEGIN, '0);
        send_item(rms_pkg::CMD_SAMPLE, 16'sh7FFF);
        send_item(rms_pkg::CMD_SAMPLE, 16'sh8000);
        send_item(rms_pkg::CMD_SAMPLE, 16'sd0);
        send_item(rms_pkg::CMD_SAMPLE, -16'sd1);
        send_item(rms_pkg::CMD_SAMPLE, 16'sd1);
        send_item(rms_pkg::CMD_SAMPLE, 16'sh7FFF);
        send_item(rms_pkg::CMD_SAMPLE, 16'sh8000);
        send_item(rms_pkg::CMD_SAMPLE, 16'sh5555);
        send_item(rms_pkg::CMD_END, 16'shFFFF);
        send_item(rms_pkg::CMD_SAMPLE, 16'sh2AAA);
        send_item(CMD_UNUSED, 16'sh8000);

        // writes to unused indexes change nothing
        settle();
        write_reg(CFG_SPARE_A, 7'h7F);
        write_reg(CFG_SPARE_B, 7'h00);

        // limit zero: first sample gives the final report, merged with intermediate
        apply_setting(7'd1, 7'd0);
        send_item(rms_pkg::CMD_BEGIN, '0);
        send_item(rms_pkg::CMD_SAMPLE, 16'sh8000);
        send_item(rms_pkg::CMD_SAMPLE, 16'sd7);

        // period zero: no intermediate reports, final after the limit
        apply_setting(7'd0, 7'd2);
        send_item(rms_pkg::CMD_BEGIN, '0);
        send_item(rms_pkg::CMD_SAMPLE, 16'sd5);
        send_item(rms_pkg::CMD_SAMPLE, -16'sd5);
        send_item(rms_pkg::CMD_SAMPLE, 16'sd7);

        // random part
        n_counted = 0;
        apply_setting(set_period[0], set_limit[0]);
        while (n_counted < TARGET_ITEMS) begin
            if (n_counted < 400) begin
                tx_idle_pct = 22;
                rx_idle_pct = 65;
            end else if (n_counted < 800) begin
                tx_idle_pct = 65;
                rx_idle_pct = 22;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (phase < 8 && n_counted >= (phase + 1) * PHASE_ITEMS) begin
                phase++;
                apply_setting(set_period[phase], set_limit[phase]);
            end
            run_session();
        end

        // drain and let the last silent sample finish
        drop_valid();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d not ignored) over %0d register settings;",
                 n_items, n_counted, n_settings);
        $display("checked %0d median reports, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
